FILE: hdl/rvx_pkg.sv
package rvx_pkg;

  // Number of implemented integer registers; x0 is always zero.
  localparam int unsigned REG_COUNT_DEFAULT = 32;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned REG_IDXW = 5;

  // Major opcodes of the implemented subset.
  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_AUIPC  = 7'b0010111;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_ALUIMM = 7'b0010011;
  localparam logic [6:0] OP_ALUREG = 7'b0110011;

  localparam logic [2:0] F3_ADD = 3'b000;
  localparam logic [6:0] F7_ADD = 7'b0000000;
  localparam logic [6:0] F7_SUB = 7'b0100000;

  // One register file write.
  typedef struct packed {
    logic                en;
    logic [REG_IDXW-1:0] idx;
    logic [XLEN-1:0]     data;
  } rf_wr_t;

  // One execute result, as it leaves the block.
  typedef struct packed {
    logic                wb_enable;
    logic [REG_IDXW-1:0] wb_index;
    logic [XLEN-1:0]     wb_value;
    logic [XLEN-1:0]     next_pc;
    logic                unsupported;
  } result_t;

endpackage

FILE: hdl/rvx_instr_if.sv
interface rvx_instr_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr;

  modport source (output valid, output instr, input ready);
  modport sink (input valid, input instr, output ready);
endinterface

FILE: hdl/rvx_result_if.sv
interface rvx_result_if;
  logic        valid;
  logic        ready;
  logic        wb_enable;
  logic [4:0]  wb_index;
  logic [31:0] wb_value;
  logic [31:0] next_pc;
  logic        unsupported;

  modport source (
    output valid, output wb_enable, output wb_index, output wb_value,
    output next_pc, output unsupported, input ready
  );
  modport sink (
    input valid, input wb_enable, input wb_index, input wb_value,
    input next_pc, input unsupported, output ready
  );
endinterface

FILE: hdl/rvx_ram.sv
module rvx_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/rvx_regfile.sv
module rvx_regfile #(
  parameter int unsigned RegCount = rvx_pkg::REG_COUNT_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [4:0]            rs1_idx_i,
  input  logic [4:0]            rs2_idx_i,
  output logic [31:0]           rs1_data_o,
  output logic [31:0]           rs2_data_o,
  input  rvx_pkg::rf_wr_t       wr_i
);
  import rvx_pkg::*;

  localparam int unsigned AddrW = $clog2(RegCount);

  logic [RegCount-1:0] valid_q;
  rf_wr_t              byp_q;
  logic [4:0]          rs_idx_q [2];
  logic [4:0]          rs_idx   [2];
  logic [XLEN-1:0]     rdata    [2];
  logic [XLEN-1:0]     rs_data  [2];

  assign rs_idx[0] = rs1_idx_i;
  assign rs_idx[1] = rs2_idx_i;

  // Two copies of the file, written together, give two read ports.
  for (genvar p = 0; p < 2; p++) begin : g_port
    rvx_ram #(
      .Width (XLEN),
      .Depth (RegCount)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr_i.en),
      .waddr_i (wr_i.idx[AddrW-1:0]),
      .wdata_i (wr_i.data),
      .re_i    (rd_en_i),
      .raddr_i (rs_idx[p][AddrW-1:0]),
      .rdata_o (rdata[p])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      byp_q   <= '0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.idx[AddrW-1:0]] <= 1'b1;
        byp_q                        <= wr_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rs_idx_q[0] <= rs1_idx_i;
      rs_idx_q[1] <= rs2_idx_i;
    end
  end

  // The bypass register holds the latest write, which the memory read
  // issued at the same edge did not yet see. Entries never written read zero.
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      priority if (rs_idx_q[p] == '0 || {1'b0, rs_idx_q[p]} >= 6'(RegCount)) begin
        rs_data[p] = '0;
      end else if (byp_q.en && byp_q.idx == rs_idx_q[p]) begin
        rs_data[p] = byp_q.data;
      end else if (valid_q[rs_idx_q[p][AddrW-1:0]]) begin
        rs_data[p] = rdata[p];
      end else begin
        rs_data[p] = '0;
      end
    end
  end

  assign rs1_data_o = rs_data[0];
  assign rs2_data_o = rs_data[1];

endmodule

FILE: hdl/rvx_exec.sv
module rvx_exec #(
  parameter int unsigned RegCount = rvx_pkg::REG_COUNT_DEFAULT
) (
  input  logic [31:0]      instr_i,
  input  logic [31:0]      pc_i,
  input  logic [31:0]      rs1_val_i,
  input  logic [31:0]      rs2_val_i,
  output rvx_pkg::result_t res_o
);
  import rvx_pkg::*;

  logic [6:0]      op;
  logic [4:0]      dst;
  logic [2:0]      f3;
  logic [6:0]      f7;
  logic [XLEN-1:0] imm_i;
  logic [XLEN-1:0] imm_j;
  logic [XLEN-1:0] imm_u;
  logic [XLEN-1:0] link;
  logic [XLEN-1:0] jalr_sum;
  logic [XLEN-1:0] val;
  logic [XLEN-1:0] nxt;
  logic            writes;
  logic            bad;
  logic            en;

  assign op  = instr_i[6:0];
  assign dst = instr_i[11:7];
  assign f3  = instr_i[14:12];
  assign f7  = instr_i[31:25];

  assign imm_i = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_j = {{12{instr_i[31]}}, instr_i[19:12], instr_i[20], instr_i[30:21], 1'b0};
  assign imm_u = {instr_i[31:12], 12'b0};

  assign link     = pc_i + 32'd4;
  assign jalr_sum = rs1_val_i + imm_i;

  always_comb begin
    val    = '0;
    nxt    = link;
    writes = 1'b0;
    bad    = 1'b0;
    unique case (op)
      OP_LUI: begin
        val    = imm_u;
        writes = 1'b1;
      end
      OP_AUIPC: begin
        val    = pc_i + imm_u;
        writes = 1'b1;
      end
      OP_JAL: begin
        val    = link;
        nxt    = pc_i + imm_j;
        writes = 1'b1;
      end
      OP_JALR: begin
        if (f3 == F3_ADD) begin
          val    = link;
          nxt    = {jalr_sum[XLEN-1:1], 1'b0};
          writes = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      OP_ALUIMM: begin
        if (f3 == F3_ADD) begin
          val    = jalr_sum;
          writes = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      OP_ALUREG: begin
        if (f3 == F3_ADD && f7 == F7_ADD) begin
          val    = rs1_val_i + rs2_val_i;
          writes = 1'b1;
        end else if (f3 == F3_ADD && f7 == F7_SUB) begin
          val    = rs1_val_i - rs2_val_i;
          writes = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  assign en = writes && dst != '0 && {1'b0, dst} < 6'(RegCount);

  assign res_o.wb_enable   = en;
  assign res_o.wb_index    = en ? dst : '0;
  assign res_o.wb_value    = en ? val : '0;
  assign res_o.next_pc     = nxt;
  assign res_o.unsupported = bad;

endmodule

FILE: hdl/rv32i_subset_execute.sv
// An accepted instruction moves through the execute stage and then the output register.
// Throughput: one instruction per cycle while results are taken, set by the register file memories,
// which take both source reads in the accept cycle and the write back in the execute cycle.
// Input ready drops only while an executed instruction waits behind an untaken result.
// Reset clears the program counter, the register valid bits, the bypass and all valid
// flags; no clearing pass is needed, and the first instruction may be accepted at once.
module rv32i_subset_execute #(
  parameter int unsigned RegCount = rvx_pkg::REG_COUNT_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  rvx_instr_if.sink           instr_i,
  rvx_result_if.source        result_o
);
  import rvx_pkg::*;

  // Execute stage: the instruction whose source operands are being read out
  // of the register file memories this cycle.
  logic            s1_valid_q;
  logic [31:0]     instr_q;
  logic [XLEN-1:0] pc_q;
  logic [XLEN-1:0] pc_d;
  logic            s1_fire;
  logic            accept;

  // Output register: one finished transaction waiting for the sink.
  logic            out_valid_q;
  result_t         out_q;

  logic [XLEN-1:0] rs1_val;
  logic [XLEN-1:0] rs2_val;
  result_t         res;
  rf_wr_t          rf_wr;

  // The execute stage moves on whenever the output register is free or is
  // emptied in the same cycle, so a new transaction can enter behind it.
  assign s1_fire       = s1_valid_q && (!out_valid_q || result_o.ready);
  assign instr_i.ready = !s1_valid_q || s1_fire;
  assign accept        = instr_i.valid && instr_i.ready;

  // Source reads are issued straight from the incoming instruction word so
  // the data arrives together with the instruction in the execute stage.
  rvx_regfile #(
    .RegCount (RegCount)
  ) u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rs1_idx_i  (instr_i.instr[19:15]),
    .rs2_idx_i  (instr_i.instr[24:20]),
    .rs1_data_o (rs1_val),
    .rs2_data_o (rs2_val),
    .wr_i       (rf_wr)
  );

  rvx_exec #(
    .RegCount (RegCount)
  ) u_exec (
    .instr_i   (instr_q),
    .pc_i      (pc_q),
    .rs1_val_i (rs1_val),
    .rs2_val_i (rs2_val),
    .res_o     (res)
  );

  // The write back and the program counter update commit together, at the
  // edge where the result enters the output register.
  assign rf_wr.en   = s1_fire && res.wb_enable;
  assign rf_wr.idx  = res.wb_index;
  assign rf_wr.data = res.wb_value;

  assign pc_d = s1_fire ? res.next_pc : pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
    end else begin
      pc_q <= pc_d;
      if (instr_i.ready) begin
        s1_valid_q <= instr_i.valid;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      instr_q <= instr_i.instr;
    end
    if (s1_fire) begin
      out_q <= res;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.wb_enable   = out_q.wb_enable;
  assign result_o.wb_index    = out_q.wb_index;
  assign result_o.wb_value    = out_q.wb_value;
  assign result_o.next_pc     = out_q.next_pc;
  assign result_o.unsupported = out_q.unsupported;

  // The program counter only moves when an instruction executes.
  a_pc_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(pc_q))
    else $error("program counter changed without an executed instruction");

  // An accepted transaction always lands in the execute stage.
  a_accept_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted instruction lost before execute");

  // x0 is never reported as written.
  a_no_x0_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_wr.en |-> rf_wr.idx != '0)
    else $error("write back to x0");

  // An instruction outside the subset never writes a register.
  a_bad_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.unsupported |-> !out_q.wb_enable)
    else $error("unsupported instruction wrote a register");

endmodule

FILE: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rvx_pkg::*;

  logic clk_i;
  logic rst_ni;

  rvx_instr_if  instr_if ();
  rvx_result_if result_if ();

  rv32i_subset_execute dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .instr_i  (instr_if),
    .result_o (result_if)
  );

  // Architectural state as the testbench sees it. It advances when an
  // instruction transaction is accepted, so the expected results line up
  // with the order in which the block must retire them.
  logic [XLEN-1:0] arch_regs [32];
  logic [XLEN-1:0] arch_pc;

  // Expected retire records, oldest first.
  result_t retire_q [$];

  // Percentage of sent instructions (sender) or cycles (result side) on which a short idle burst starts.
  // Zero turns idling off on both sides.
  int unsigned idle_pct;
  int unsigned error_count;
  int unsigned result_count;

  // The clock runs at 50 MHz.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // A generous upper bound on the run. The slowest correct run is roughly
  // 1600 instructions with sender gaps and receiver stalls,
  // well under 300 us.
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Instruction encoders for the formats used by the subset.
  function automatic logic [31:0] enc_u(input logic [6:0] op, input logic [4:0] rd,
                                        input logic [19:0] imm20);
    return {imm20, rd, op};
  endfunction

  function automatic logic [31:0] enc_i(input logic [6:0] op, input logic [4:0] rd,
                                        input logic [2:0] f3, input logic [4:0] rs1,
                                        input logic [11:0] imm12);
    return {imm12, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OP_ALUREG};
  endfunction

  // The J-type offset is a byte offset; bit 0 is dropped by the encoding.
  function automatic logic [31:0] enc_j(input logic [4:0] rd, input logic [20:0] offs);
    return {offs[20], offs[10:1], offs[11], offs[19:12], rd, OP_JAL};
  endfunction

  // x0 reads as zero, and so does any index past the implemented registers.
  function automatic logic [XLEN-1:0] gpr_read(input logic [4:0] idx);
    if (idx == 5'd0 || idx >= REG_COUNT_DEFAULT) return '0;
    return arch_regs[idx];
  endfunction

  // Executes one instruction against the architectural state and returns
  // the record the block should produce for it.
  function automatic result_t retire_instr(input logic [31:0] word);
    logic [6:0]      op;
    logic [4:0]      rd;
    logic [2:0]      f3;
    logic [6:0]      f7;
    logic [XLEN-1:0] imm_i;
    logic [XLEN-1:0] imm_j;
    logic [XLEN-1:0] link;
    logic [XLEN-1:0] nxt;
    logic [XLEN-1:0] val;
    logic            writes;
    logic            bad;
    result_t         res;

    op     = word[6:0];
    rd     = word[11:7];
    f3     = word[14:12];
    f7     = word[31:25];
    imm_i  = {{20{word[31]}}, word[31:20]};
    imm_j  = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
    link   = arch_pc + 32'd4;
    nxt    = link;
    val    = '0;
    writes = 1'b0;
    bad    = 1'b0;

    case (op)
      OP_LUI: begin
        val    = {word[31:12], 12'd0};
        writes = 1'b1;
      end
      OP_AUIPC: begin
        val    = arch_pc + {word[31:12], 12'd0};
        writes = 1'b1;
      end
      OP_JAL: begin
        val    = link;
        nxt    = arch_pc + imm_j;
        writes = 1'b1;
      end
      OP_JALR: begin
        if (f3 == F3_ADD) begin
          // The source is read before the link value lands, which matters
          // when source and destination are the same register.
          nxt    = (gpr_read(word[19:15]) + imm_i) & ~32'd1;
          val    = link;
          writes = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      OP_ALUIMM: begin
        if (f3 == F3_ADD) begin
          val    = gpr_read(word[19:15]) + imm_i;
          writes = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      OP_ALUREG: begin
        if (f3 == F3_ADD && f7 == F7_ADD) begin
          val    = gpr_read(word[19:15]) + gpr_read(word[24:20]);
          writes = 1'b1;
        end else if (f3 == F3_ADD && f7 == F7_SUB) begin
          val    = gpr_read(word[19:15]) - gpr_read(word[24:20]);
          writes = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase

    res.wb_enable   = writes && rd != 5'd0 && rd < REG_COUNT_DEFAULT;
    res.wb_index    = res.wb_enable ? rd : 5'd0;
    res.wb_value    = res.wb_enable ? val : '0;
    res.next_pc     = nxt;
    res.unsupported = bad;
    if (res.wb_enable) arch_regs[rd] = val;
    arch_pc = nxt;
    return res;
  endfunction

  // Presents one instruction, holds it until the block takes it, and books
  // the expected result at the accepting edge. Called and left at a falling
  // edge, so valid stays high between back-to-back transactions.
  task automatic send_instr(input logic [31:0] word);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      instr_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    instr_if.valid <= 1'b1;
    instr_if.instr <= word;
    do @(posedge clk_i); while (!instr_if.ready);
    retire_q.push_back(retire_instr(word));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (retire_q.size() != 0) @(negedge clk_i);
  endtask

  // Random instruction mix: mostly the implemented subset with random
  // registers and immediates, plus near-miss encodings and raw noise.
  function automatic logic [31:0] rand_instr();
    int unsigned sel;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] bits;

    sel  = $urandom_range(0, 99);
    rd   = 5'($urandom_range(0, 31));
    rs1  = 5'($urandom_range(0, 31));
    rs2  = 5'($urandom_range(0, 31));
    bits = $urandom();
    if (sel < 8)  return enc_u(OP_LUI, rd, bits[19:0]);
    if (sel < 16) return enc_u(OP_AUIPC, rd, bits[19:0]);
    if (sel < 26) return enc_j(rd, bits[20:0]);
    if (sel < 36) return enc_i(OP_JALR, rd, F3_ADD, rs1, bits[11:0]);
    if (sel < 58) return enc_i(OP_ALUIMM, rd, F3_ADD, rs1, bits[11:0]);
    if (sel < 70) return enc_r(F7_ADD, rs2, rs1, F3_ADD, rd);
    if (sel < 80) return enc_r(F7_SUB, rs2, rs1, F3_ADD, rd);
    if (sel < 84) return enc_i(OP_JALR, rd, 3'($urandom_range(1, 7)), rs1, bits[11:0]);
    if (sel < 88) return enc_i(OP_ALUIMM, rd, 3'($urandom_range(1, 7)), rs1, bits[11:0]);
    if (sel < 92) return enc_r(bits[31:25], rs2, rs1, bits[14:12], rd);
    return bits;
  endfunction

  // Every special case of the subset once, starting from the reset state.
  task automatic test_directed_cases();
    send_instr(enc_u(OP_LUI, 5'd1, 20'hFFFFF));
    // A write to x0 is computed and dropped.
    send_instr(enc_u(OP_LUI, 5'd0, 20'hABCDE));
    send_instr(enc_u(OP_AUIPC, 5'd2, 20'h80000));
    send_instr(enc_i(OP_ALUIMM, 5'd3, F3_ADD, 5'd0, 12'hFFF));
    send_instr(enc_i(OP_ALUIMM, 5'd4, F3_ADD, 5'd3, 12'h7FF));
    send_instr(enc_i(OP_ALUIMM, 5'd31, F3_ADD, 5'd1, 12'h800));
    send_instr(enc_r(F7_ADD, 5'd4, 5'd3, F3_ADD, 5'd5));
    send_instr(enc_r(F7_ADD, 5'd3, 5'd3, F3_ADD, 5'd0));
    send_instr(enc_r(F7_SUB, 5'd3, 5'd0, F3_ADD, 5'd6));
    send_instr(enc_r(F7_SUB, 5'd31, 5'd1, F3_ADD, 5'd7));
    // The largest upper immediate is added to the counter.
    send_instr(enc_u(OP_AUIPC, 5'd8, 20'hFFFFF));
    // Largest forward jump, largest backward jump as a plain jump, and a
    // jump to an address that is not word aligned.
    send_instr(enc_j(5'd9, 21'h0FFFFE));
    send_instr(enc_j(5'd0, 21'h100000));
    send_instr(enc_j(5'd10, 21'h000006));
    // Indirect jumps: bit 0 cleared, source equal to destination, and a
    // plain indirect jump with x0 as destination.
    send_instr(enc_i(OP_JALR, 5'd11, F3_ADD, 5'd3, 12'h000));
    send_instr(enc_i(OP_JALR, 5'd11, F3_ADD, 5'd11, 12'h7FF));
    send_instr(enc_i(OP_JALR, 5'd0, F3_ADD, 5'd4, 12'h801));
    // Encodings outside the subset, followed by one register add.
    send_instr(enc_i(OP_JALR, 5'd12, 3'd1, 5'd3, 12'h123));
    send_instr(enc_i(OP_ALUIMM, 5'd12, 3'd7, 5'd3, 12'hFFF));
    send_instr(enc_r(7'h01, 5'd3, 5'd4, F3_ADD, 5'd12));
    send_instr(enc_r(F7_ADD, 5'd3, 5'd4, 3'd4, 5'd12));
    send_instr(enc_r(F7_SUB, 5'd3, 5'd4, 3'd5, 5'd12));
    send_instr(32'h0000_0000);
    send_instr(32'hFFFF_FFFF);
    send_instr(enc_r(F7_ADD, 5'd2, 5'd31, F3_ADD, 5'd12));
  endtask

  // Long random run in segments, each with an idling density drawn at random
  // from 0, 15 and 40 percent.
  task automatic test_random_mix();
    int seg;
    for (seg = 0; seg < 12; seg++) begin
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 40;
      endcase
      repeat (100) send_instr(rand_instr());
    end
  endtask

  // The sender holds off until every booked result has come back, then
  // resumes from an empty pipeline.
  task automatic test_pause_until_drained();
    idle_pct = 20;
    repeat (20) send_instr(rand_instr());
    instr_if.valid <= 1'b0;
    wait_drained();
    @(negedge clk_i);
    repeat (20) send_instr(rand_instr());
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_back_to_back_tail();
    idle_pct = 0;
    repeat (300) send_instr(rand_instr());
  endtask

  // Result side: ready is lowered in random bursts while idling is on.
  initial begin
    int unsigned stall_left;
    stall_left      = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        result_if.ready <= 1'b0;
        stall_left--;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        result_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // Each result transaction is matched against the oldest booked result.
  always @(posedge clk_i) begin
    result_t exp_res;
    if (rst_ni && result_if.valid && result_if.ready) begin
      result_count++;
      if (retire_q.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing expected", result_count));
      end else begin
        exp_res = retire_q.pop_front();
        if (result_if.wb_enable !== exp_res.wb_enable)
          report_error($sformatf("result %0d wb_enable %b, expected %b", result_count,
                                 result_if.wb_enable, exp_res.wb_enable));
        if (result_if.wb_index !== exp_res.wb_index)
          report_error($sformatf("result %0d wb_index %0d, expected %0d", result_count,
                                 result_if.wb_index, exp_res.wb_index));
        if (result_if.wb_value !== exp_res.wb_value)
          report_error($sformatf("result %0d wb_value %h, expected %h", result_count,
                                 result_if.wb_value, exp_res.wb_value));
        if (result_if.next_pc !== exp_res.next_pc)
          report_error($sformatf("result %0d next_pc %h, expected %h", result_count,
                                 result_if.next_pc, exp_res.next_pc));
        if (result_if.unsupported !== exp_res.unsupported)
          report_error($sformatf("result %0d unsupported %b, expected %b", result_count,
                                 result_if.unsupported, exp_res.unsupported));
      end
    end
  end

  initial begin
    int i;
    error_count    = 0;
    result_count   = 0;
    idle_pct       = 0;
    arch_pc        = '0;
    for (i = 0; i < 32; i++) arch_regs[i] = '0;
    instr_if.valid = 1'b0;
    instr_if.instr = '0;
    rst_ni         = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idle_pct = 25;
    test_directed_cases();
    test_random_mix();
    test_pause_until_drained();
    test_back_to_back_tail();

    instr_if.valid <= 1'b0;
    wait_drained();
    // The spare cycles below catch any result the block emits beyond those expected.
    repeat (4) @(negedge clk_i);
    if (retire_q.size() != 0)
      report_error($sformatf("%0d expected results never arrived", retire_q.size()));

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
